// File: rtl/cts_pkg.sv
// cts_pkg: shared constants, record types and character helpers for the
// C-style token scanner. Used by cts_scan, cts_rsp_queue and the top level.
// No dependencies.
package cts_pkg;

   localparam int POSITION_BITS = 32;
   localparam int LENGTH_BITS   = 16;
   localparam int WORD_BITS     = 48;   // last six characters of a word

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [LENGTH_BITS-1:0]   len_type;
   typedef logic [WORD_BITS-1:0]     word_type;

   // token kinds
   localparam logic [3:0] KIND_NUM     = 4'd0;
   localparam logic [3:0] KIND_KEYWORD = 4'd1;
   localparam logic [3:0] KIND_IDENT   = 4'd2;
   localparam logic [3:0] KIND_INCDEC  = 4'd3;
   localparam logic [3:0] KIND_BINOP   = 4'd4;
   localparam logic [3:0] KIND_DELIM   = 4'd5;
   localparam logic [3:0] KIND_SEMI    = 4'd6;
   localparam logic [3:0] KIND_ERROR   = 4'd7;
   localparam logic [3:0] KIND_END     = 4'd8;

   // keyword codes
   localparam logic [2:0] KW_NONE   = 3'd0;
   localparam logic [2:0] KW_RETURN = 3'd1;
   localparam logic [2:0] KW_WHILE  = 3'd2;
   localparam logic [2:0] KW_IF     = 3'd3;
   localparam logic [2:0] KW_ELSE   = 3'd4;
   localparam logic [2:0] KW_FOR    = 3'd5;
   localparam logic [2:0] KW_DO     = 3'd6;

   // keyword text, packed right-aligned, first character highest
   localparam word_type TXT_RETURN = 48'h72_65_74_75_72_6E;
   localparam word_type TXT_WHILE  = 48'h00_77_68_69_6C_65;
   localparam word_type TXT_IF     = 48'h00_00_00_00_69_66;
   localparam word_type TXT_ELSE   = 48'h00_00_65_6C_73_65;
   localparam word_type TXT_FOR    = 48'h00_00_00_66_6F_72;
   localparam word_type TXT_DO     = 48'h00_00_00_00_64_6F;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_LBRC  = 8'h7B;
   localparam logic [7:0] CH_RBRC  = 8'h7D;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;

   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  keyword;
      logic [31:0] start_offset;
      logic [15:0] length;
      logic        last;
   } rsp_type;

   // all results of one item, in order
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } scan_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
   endfunction

   // space, and tab through carriage return
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [2:0] keyword_code(input word_type w, input len_type n);
      logic [2:0] code;
      code = KW_NONE;
      if ((n == len_type'(6)) && (w == TXT_RETURN)) code = KW_RETURN;
      if ((n == len_type'(5)) && (w == TXT_WHILE))  code = KW_WHILE;
      if ((n == len_type'(2)) && (w == TXT_IF))     code = KW_IF;
      if ((n == len_type'(4)) && (w == TXT_ELSE))   code = KW_ELSE;
      if ((n == len_type'(3)) && (w == TXT_FOR))    code = KW_FOR;
      if ((n == len_type'(2)) && (w == TXT_DO))     code = KW_DO;
      return code;
   endfunction

   function automatic rsp_type make_rec(input logic [3:0] kind, input logic [2:0] kw,
                                        input pos_type start, input len_type n);
      rsp_type r;
      r.kind         = kind;
      r.keyword      = kw;
      r.start_offset = 32'(start);
      r.length       = 16'(n);
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

// File: rtl/cts_scan.sv
// cts_scan: scanner state registers and the per-beat next-state / token logic.
// Produces up to two token records per beat. Depends on cts_pkg.
module cts_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_vld,
   input  logic [7:0]             item_ch,
   input  logic                   item_end,
   output cts_pkg::scan_out_type  res
);

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_INT   = 3'd1;
   localparam logic [2:0] MODE_FRAC  = 3'd2;
   localparam logic [2:0] MODE_WORD  = 3'd3;
   localparam logic [2:0] MODE_PEND  = 3'd4;
   localparam logic [2:0] MODE_LINE  = 3'd5;
   localparam logic [2:0] MODE_BLOCK = 3'd6;
   localparam logic [2:0] MODE_BSTAR = 3'd7;

   logic [2:0]        mode_ff,  mode_in;
   logic [7:0]        pend_ff,  pend_in;
   cts_pkg::word_type word_ff,  word_in;
   cts_pkg::pos_type  start_ff, start_in;
   cts_pkg::len_type  tlen_ff,  tlen_in;
   cts_pkg::pos_type  pos_ff,   pos_in;
   logic              fin_ff,   fin_in;

   logic              do_flush, do_idle;
   logic              a_vld, b_vld;
   cts_pkg::rsp_type  a_rec, b_rec;
   logic [2:0]        kw;

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      word_in  = word_ff;
      start_in = start_ff;
      tlen_in  = tlen_ff;
      pos_in   = pos_ff;
      fin_in   = fin_ff;
      do_flush = 1'b0;
      do_idle  = 1'b0;
      a_vld    = 1'b0;
      a_rec    = '0;
      b_vld    = 1'b0;
      b_rec    = '0;
      kw       = cts_pkg::keyword_code(word_ff, tlen_ff);

      if (item_end) begin
         do_flush = !fin_ff;
         fin_in   = 1'b1;
         b_vld    = 1'b1;
         b_rec    = cts_pkg::make_rec(cts_pkg::KIND_END, cts_pkg::KW_NONE, pos_ff, '0);
      end else if (!fin_ff) begin
         pos_in = cts_pkg::pos_type'(pos_ff + 1'b1);
         case (mode_ff)
            MODE_INT, MODE_FRAC: begin
               if (cts_pkg::is_digit(item_ch) ||
                   ((item_ch == cts_pkg::CH_DOT) && (mode_ff == MODE_INT))) begin
                  if (tlen_ff != '1) tlen_in = cts_pkg::len_type'(tlen_ff + 1'b1);
                  if (!cts_pkg::is_digit(item_ch)) mode_in = MODE_FRAC;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_WORD: begin
               if (cts_pkg::is_alpha(item_ch) || cts_pkg::is_digit(item_ch) ||
                   (item_ch == cts_pkg::CH_UNDER)) begin
                  if (tlen_ff != '1) tlen_in = cts_pkg::len_type'(tlen_ff + 1'b1);
                  word_in = {word_ff[cts_pkg::WORD_BITS-9:0], item_ch};
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_PEND: begin
               if ((pend_ff == item_ch) &&
                   ((item_ch == cts_pkg::CH_PLUS) || (item_ch == cts_pkg::CH_MINUS))) begin
                  a_vld   = 1'b1;
                  a_rec   = cts_pkg::make_rec(cts_pkg::KIND_INCDEC, cts_pkg::KW_NONE,
                                              start_ff, cts_pkg::len_type'(2));
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end else if (item_ch == cts_pkg::CH_EQ) begin
                  a_vld   = 1'b1;
                  a_rec   = cts_pkg::make_rec(cts_pkg::KIND_BINOP, cts_pkg::KW_NONE,
                                              start_ff, cts_pkg::len_type'(2));
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end else if ((pend_ff == cts_pkg::CH_SLASH) &&
                            (item_ch == cts_pkg::CH_SLASH)) begin
                  mode_in = MODE_LINE;
                  pend_in = '0;
               end else if ((pend_ff == cts_pkg::CH_SLASH) &&
                            (item_ch == cts_pkg::CH_STAR)) begin
                  mode_in = MODE_BLOCK;
                  pend_in = '0;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_LINE: begin
               if ((item_ch == cts_pkg::CH_LF) || (item_ch == cts_pkg::CH_CR)) begin
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end
            end
            MODE_BLOCK: begin
               if (item_ch == cts_pkg::CH_STAR) mode_in = MODE_BSTAR;
            end
            MODE_BSTAR: begin
               if (item_ch == cts_pkg::CH_SLASH) begin
                  mode_in = MODE_IDLE;
                  pend_in = '0;
               end else if (item_ch != cts_pkg::CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: begin
               // idle
               mode_in = MODE_IDLE;
               pend_in = '0;
               do_idle = 1'b1;
            end
         endcase
      end

      // emit the token in progress
      if (do_flush) begin
         case (mode_ff)
            MODE_INT, MODE_FRAC: begin
               a_vld = 1'b1;
               a_rec = cts_pkg::make_rec(cts_pkg::KIND_NUM, cts_pkg::KW_NONE,
                                         start_ff, tlen_ff);
            end
            MODE_WORD: begin
               a_vld = 1'b1;
               a_rec = cts_pkg::make_rec((kw != cts_pkg::KW_NONE) ? cts_pkg::KIND_KEYWORD
                                                                 : cts_pkg::KIND_IDENT,
                                         kw, start_ff, tlen_ff);
            end
            MODE_PEND: begin
               a_vld = 1'b1;
               a_rec = cts_pkg::make_rec(cts_pkg::KIND_BINOP, cts_pkg::KW_NONE,
                                         start_ff, cts_pkg::len_type'(1));
            end
            default: begin
               a_vld = 1'b0;
            end
         endcase
         mode_in = MODE_IDLE;
         pend_in = '0;
      end

      if (item_end) begin
         mode_in = MODE_IDLE;
         pend_in = '0;
      end

      // scan the character from idle
      if (do_idle && !cts_pkg::is_space(item_ch)) begin
         start_in = pos_ff;
         tlen_in  = cts_pkg::len_type'(1);
         if (cts_pkg::is_digit(item_ch)) begin
            mode_in = MODE_INT;
         end else if (cts_pkg::is_alpha(item_ch)) begin
            mode_in = MODE_WORD;
            word_in = cts_pkg::word_type'(item_ch);
         end else if ((item_ch == cts_pkg::CH_PLUS) || (item_ch == cts_pkg::CH_MINUS) ||
                      (item_ch == cts_pkg::CH_STAR) || (item_ch == cts_pkg::CH_SLASH)) begin
            mode_in = MODE_PEND;
            pend_in = item_ch;
         end else begin
            b_vld = 1'b1;
            if (item_ch == cts_pkg::CH_EQ) begin
               b_rec = cts_pkg::make_rec(cts_pkg::KIND_BINOP, cts_pkg::KW_NONE,
                                         pos_ff, cts_pkg::len_type'(1));
            end else if ((item_ch == cts_pkg::CH_LPAR) || (item_ch == cts_pkg::CH_RPAR) ||
                         (item_ch == cts_pkg::CH_LBRC) || (item_ch == cts_pkg::CH_RBRC)) begin
               b_rec = cts_pkg::make_rec(cts_pkg::KIND_DELIM, cts_pkg::KW_NONE,
                                         pos_ff, cts_pkg::len_type'(1));
            end else if (item_ch == cts_pkg::CH_SEMI) begin
               b_rec = cts_pkg::make_rec(cts_pkg::KIND_SEMI, cts_pkg::KW_NONE,
                                         pos_ff, cts_pkg::len_type'(1));
            end else begin
               b_rec = cts_pkg::make_rec(cts_pkg::KIND_ERROR, cts_pkg::KW_NONE,
                                         pos_ff, cts_pkg::len_type'(1));
            end
         end
      end

      // pack results in order, mark the final one
      res.cnt     = {1'b0, a_vld} + {1'b0, b_vld};
      res.r0      = a_vld ? a_rec : b_rec;
      res.r0.last = !(a_vld && b_vld);
      res.r1      = b_rec;
      res.r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= '0;
         word_ff  <= '0;
         start_ff <= '0;
         tlen_ff  <= '0;
         pos_ff   <= '0;
         fin_ff   <= 1'b0;
      end else if (item_vld) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         word_ff  <= word_in;
         start_ff <= start_in;
         tlen_ff  <= tlen_in;
         pos_ff   <= pos_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// File: rtl/cts_rsp_queue.sv
// cts_rsp_queue: two-entry result buffer between the scanner and the rsp port.
// Loads a whole beat's results at once, drains one per beat. Depends on cts_pkg.
module cts_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cts_pkg::scan_out_type din,
   input  logic                  out_stall,
   output logic                  out_valid,
   output cts_pkg::rsp_type      dout,
   output logic                  room
);

   logic [1:0]       cnt_ff, cnt_in;
   cts_pkg::rsp_type slot0_ff, slot0_in;
   cts_pkg::rsp_type slot1_ff, slot1_in;
   logic             pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign dout      = slot0_ff;
   assign pop       = out_valid && !out_stall;
   // room for two results once this cycle's pop is counted
   assign room      = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         cnt_in   = din.cnt;
         slot0_in = din.r0;
         slot1_in = din.r1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: rtl/c_style_token_scanner.sv
// c_style_token_scanner: top level of the C-style token scanner.
// Input register, cts_scan and cts_rsp_queue. Depends on cts_pkg.
//
//   channel | ports                                   | beat carries
//   --------+-----------------------------------------+------------------------------
//   req     | req_valid, req_stall, req_ch,           | one character or end mark
//           | req_end_mark                            |
//   rsp     | rsp_valid, rsp_stall, rsp_kind,         | one token record; rsp_last
//           | rsp_keyword, rsp_start_offset,          | flags the final record of a
//           | rsp_length, rsp_last                    | req beat
//
// Cycles: one req beat per cycle sustained while rsp_stall is low and no beat yields
//   two records. A req beat lands in the input register, is scanned once the
//   result queue has room and its records are registered in that queue, which
//   drives rsp. After a two-record beat the next beat waits until the queue drains.
// Reset: synchronous, clears scanner state and both valids; no clearing pass.
// Stalls: rsp_stall feeds straight through to req_stall when the input
//   register is occupied and the result queue lacks room for two records.
module c_style_token_scanner (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_mark,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [2:0]  rsp_keyword,
   output logic [31:0] rsp_start_offset,
   output logic [15:0] rsp_length,
   output logic        rsp_last
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_ch_ff;
   logic       in_end_ff;

   logic                  accept;   // req beat taken
   logic                  adv;      // input register moves into the scanner
   logic                  room;
   cts_pkg::scan_out_type scan_res;
   cts_pkg::rsp_type      front;

   // scanner advances only if the queue can take two records this cycle
   assign adv       = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_end_mark;
      end
   end

   cts_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .item_vld (adv),
      .item_ch  (in_ch_ff),
      .item_end (in_end_ff),
      .res      (scan_res)
   );

   cts_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (adv),
      .din       (scan_res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .dout      (front),
      .room      (room)
   );

   assign rsp_kind         = front.kind;
   assign rsp_keyword      = front.keyword;
   assign rsp_start_offset = front.start_offset;
   assign rsp_length       = front.length;
   assign rsp_last         = front.last;

   // stall back to the source only with a beat held
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("req_stall raised with empty input register");

   // an end mark always yields at least the end record
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (adv && in_end_ff) |=> rsp_valid)
      else $error("end mark scanned but no record queued");

   // the partner of a non-final record is already queued behind it
   a_pair_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("second record of a beat missing");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for c_style_token_scanner.
// Needs cts_pkg and the scanner RTL; a built-in token predictor checks every rsp beat.
module tb_top;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT ports
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_end_mark = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [2:0]  rsp_keyword;
   logic [31:0] rsp_start_offset;
   logic [15:0] rsp_length;
   logic        rsp_last;

   c_style_token_scanner uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_mark     (req_end_mark),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_keyword      (rsp_keyword),
      .rsp_start_offset (rsp_start_offset),
      .rsp_length       (rsp_length),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Stimulus store and traffic shaping
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [7:0] ch;
      logic       endm;
   } char_beat_type;

   char_beat_type    char_q [$];        // beats waiting for the driver
   cts_pkg::rsp_type token_expect [$];  // predicted token records, oldest first
   int               chars_queued = 0;

   int send_idle = 33;            // percent of cycles the sender holds back
   int recv_idle = 87;            // percent of cycles the receiver stalls
   bit hold_req  = 1'b0;          // ask the receiver for one long hold-off
   bit hold_used = 1'b0;
   int hold_cnt  = 0;

   logic req_fire    = 1'b0;      // req beat taken at the last rising edge
   logic stream_idle = 1'b0;      // nothing queued, offered or expected
   int   err_cnt     = 0;
   int   tok_seen    = 0;

   localparam logic [47:0] W_RETURN = "return";
   localparam logic [47:0] W_WHILE  = "while";
   localparam logic [47:0] W_IF     = "if";
   localparam logic [47:0] W_ELSE   = "else";
   localparam logic [47:0] W_FOR    = "for";
   localparam logic [47:0] W_DO     = "do";

   logic [7:0] blanks     [6] = '{cts_pkg::CH_SPACE, cts_pkg::CH_TAB, cts_pkg::CH_LF,
                                  8'h0B, 8'h0C, cts_pkg::CH_CR};
   logic [7:0] op_chars   [4] = '{cts_pkg::CH_PLUS, cts_pkg::CH_MINUS, cts_pkg::CH_STAR,
                                  cts_pkg::CH_SLASH};
   logic [7:0] single_ops [5] = '{cts_pkg::CH_EQ, cts_pkg::CH_PLUS, cts_pkg::CH_MINUS,
                                  cts_pkg::CH_STAR, cts_pkg::CH_SLASH};
   logic [7:0] delims     [5] = '{cts_pkg::CH_LPAR, cts_pkg::CH_RPAR, cts_pkg::CH_LBRC,
                                  cts_pkg::CH_RBRC, cts_pkg::CH_SEMI};
   // second char after a pending symbol; never '/' or '*' so no comment opens
   logic [7:0] follow     [8] = '{cts_pkg::CH_PLUS, cts_pkg::CH_MINUS, cts_pkg::CH_EQ,
                                  cts_pkg::CH_SEMI, cts_pkg::CH_LPAR,
                                  8'h61, 8'h31, cts_pkg::CH_SPACE};
   logic [7:0] cmt_fill   [4] = '{8'h61, cts_pkg::CH_SPACE, cts_pkg::CH_STAR,
                                  cts_pkg::CH_SLASH};
   string kw_words [6] = '{"return", "while", "if", "else", "for", "do"};
   string stmts    [5] = '{"while(i<10)i++;", "return a*b;", "for(;;){}",
                           "do x--;while(y)", "else{z/=3;}"};
   string tails    [8] = '{"", "ab", "12", "+", "//x", "/* x", "/* *", "return"};

   // ---------------------------------------------------------------------
   // Token predictor: its own scanner state, advanced once per req beat
   // ---------------------------------------------------------------------
   localparam logic [2:0] SM_IDLE  = 3'd0;
   localparam logic [2:0] SM_INT   = 3'd1;
   localparam logic [2:0] SM_FRAC  = 3'd2;
   localparam logic [2:0] SM_WORD  = 3'd3;
   localparam logic [2:0] SM_PEND  = 3'd4;
   localparam logic [2:0] SM_LINE  = 3'd5;
   localparam logic [2:0] SM_BLOCK = 3'd6;
   localparam logic [2:0] SM_BSTAR = 3'd7;

   logic [2:0]       sc_mode;
   logic [7:0]       sc_pend;
   logic [47:0]      sc_word;    // last six word characters
   logic [31:0]      sc_start;
   logic [15:0]      sc_len;     // saturates at all ones
   logic [31:0]      sc_pos;     // index of the next character, wraps
   logic             sc_done;    // end mark seen
   cts_pkg::rsp_type step_out [2];
   int               step_cnt;

   function automatic logic chr_num(input logic [7:0] c);
      return c >= cts_pkg::CH_0 && c <= cts_pkg::CH_9;
   endfunction

   function automatic logic chr_letter(input logic [7:0] c);
      return (c >= cts_pkg::CH_LA && c <= cts_pkg::CH_LZ) ||
             (c >= cts_pkg::CH_UA && c <= cts_pkg::CH_UZ);
   endfunction

   function automatic logic chr_blank(input logic [7:0] c);
      return c == cts_pkg::CH_SPACE || (c >= cts_pkg::CH_TAB && c <= cts_pkg::CH_CR);
   endfunction

   function automatic logic [2:0] kw_lookup(input logic [47:0] w, input logic [15:0] n);
      case (n)
         16'd2:   return (w == W_IF) ? cts_pkg::KW_IF :
                         (w == W_DO) ? cts_pkg::KW_DO : cts_pkg::KW_NONE;
         16'd3:   return (w == W_FOR) ? cts_pkg::KW_FOR : cts_pkg::KW_NONE;
         16'd4:   return (w == W_ELSE) ? cts_pkg::KW_ELSE : cts_pkg::KW_NONE;
         16'd5:   return (w == W_WHILE) ? cts_pkg::KW_WHILE : cts_pkg::KW_NONE;
         16'd6:   return (w == W_RETURN) ? cts_pkg::KW_RETURN : cts_pkg::KW_NONE;
         default: return cts_pkg::KW_NONE;
      endcase
   endfunction

   function automatic void emit_tok(input logic [3:0] k, input logic [2:0] kw,
                                    input logic [31:0] st, input logic [15:0] ln);
      step_out[step_cnt] = '{kind: k, keyword: kw, start_offset: st, length: ln, last: 1'b0};
      step_cnt++;
   endfunction

   function automatic void lengthen();
      if (sc_len != 16'hFFFF) sc_len++;
   endfunction

   // emit the token in progress, if any, and fall back to idle
   function automatic void flush_tok();
      logic [2:0] kw;
      case (sc_mode)
         SM_INT, SM_FRAC: emit_tok(cts_pkg::KIND_NUM, cts_pkg::KW_NONE, sc_start, sc_len);
         SM_WORD: begin
            kw = kw_lookup(sc_word, sc_len);
            emit_tok((kw != cts_pkg::KW_NONE) ? cts_pkg::KIND_KEYWORD : cts_pkg::KIND_IDENT,
                     kw, sc_start, sc_len);
         end
         SM_PEND: emit_tok(cts_pkg::KIND_BINOP, cts_pkg::KW_NONE, sc_start, 16'd1);
         default: ;
      endcase
      sc_mode = SM_IDLE;
      sc_pend = 8'h00;
   endfunction

   // character seen from idle
   function automatic void begin_tok(input logic [7:0] c);
      if (chr_blank(c)) return;
      sc_start = sc_pos;
      sc_len   = 16'd1;
      if (chr_num(c)) begin
         sc_mode = SM_INT;
      end else if (chr_letter(c)) begin
         sc_mode = SM_WORD;
         sc_word = {40'd0, c};
      end else if (c == cts_pkg::CH_PLUS || c == cts_pkg::CH_MINUS ||
                   c == cts_pkg::CH_STAR || c == cts_pkg::CH_SLASH) begin
         sc_mode = SM_PEND;
         sc_pend = c;
      end else if (c == cts_pkg::CH_EQ) begin
         emit_tok(cts_pkg::KIND_BINOP, cts_pkg::KW_NONE, sc_pos, 16'd1);
      end else if (c == cts_pkg::CH_LPAR || c == cts_pkg::CH_RPAR ||
                   c == cts_pkg::CH_LBRC || c == cts_pkg::CH_RBRC) begin
         emit_tok(cts_pkg::KIND_DELIM, cts_pkg::KW_NONE, sc_pos, 16'd1);
      end else if (c == cts_pkg::CH_SEMI) begin
         emit_tok(cts_pkg::KIND_SEMI, cts_pkg::KW_NONE, sc_pos, 16'd1);
      end else begin
         emit_tok(cts_pkg::KIND_ERROR, cts_pkg::KW_NONE, sc_pos, 16'd1);
      end
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      logic [7:0] p;
      p = sc_pend;
      case (sc_mode)
         SM_INT, SM_FRAC: begin
            if (chr_num(c)) begin
               lengthen();
            end else if (c == cts_pkg::CH_DOT && sc_mode == SM_INT) begin
               lengthen();
               sc_mode = SM_FRAC;
            end else begin
               // a second point lands here and becomes an error token
               flush_tok();
               begin_tok(c);
            end
         end
         SM_WORD: begin
            if (chr_letter(c) || chr_num(c) || c == cts_pkg::CH_UNDER) begin
               lengthen();
               sc_word = {sc_word[39:0], c};
            end else begin
               flush_tok();
               begin_tok(c);
            end
         end
         SM_PEND: begin
            if ((p == cts_pkg::CH_PLUS && c == cts_pkg::CH_PLUS) ||
                (p == cts_pkg::CH_MINUS && c == cts_pkg::CH_MINUS)) begin
               emit_tok(cts_pkg::KIND_INCDEC, cts_pkg::KW_NONE, sc_start, 16'd2);
               sc_mode = SM_IDLE;
               sc_pend = 8'h00;
            end else if (c == cts_pkg::CH_EQ) begin
               emit_tok(cts_pkg::KIND_BINOP, cts_pkg::KW_NONE, sc_start, 16'd2);
               sc_mode = SM_IDLE;
               sc_pend = 8'h00;
            end else if (p == cts_pkg::CH_SLASH && c == cts_pkg::CH_SLASH) begin
               sc_mode = SM_LINE;
               sc_pend = 8'h00;
            end else if (p == cts_pkg::CH_SLASH && c == cts_pkg::CH_STAR) begin
               sc_mode = SM_BLOCK;   // opening star cannot close it
               sc_pend = 8'h00;
            end else begin
               flush_tok();
               begin_tok(c);
            end
         end
         SM_LINE: begin
            if (c == cts_pkg::CH_LF || c == cts_pkg::CH_CR) begin
               sc_mode = SM_IDLE;
               sc_pend = 8'h00;
            end
         end
         SM_BLOCK: begin
            if (c == cts_pkg::CH_STAR) sc_mode = SM_BSTAR;
         end
         SM_BSTAR: begin
            if (c == cts_pkg::CH_SLASH) begin
               sc_mode = SM_IDLE;
               sc_pend = 8'h00;
            end else if (c != cts_pkg::CH_STAR) begin
               sc_mode = SM_BLOCK;
            end
         end
         default: begin
            sc_pend = 8'h00;
            begin_tok(c);
         end
      endcase
   endfunction

   // advance the predictor by one accepted beat, queue what it yields
   function automatic void predict_tokens(input logic [7:0] c, input logic endm);
      step_cnt = 0;
      if (endm) begin
         // open comments just vanish; a pending symbol flushes as an op
         if (!sc_done) flush_tok();
         sc_mode = SM_IDLE;
         sc_pend = 8'h00;
         emit_tok(cts_pkg::KIND_END, cts_pkg::KW_NONE, sc_pos, 16'd0);
         sc_done = 1'b1;
      end else if (!sc_done) begin
         scan_char(c);
         sc_pos++;
      end
      // characters after the end mark are dropped without a token
      if (step_cnt > 0) step_out[step_cnt-1].last = 1'b1;
      for (int i = 0; i < step_cnt; i++) token_expect.push_back(step_out[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_cnt++;
      $display("mismatch at token %0d, %s: got 0x%0h, expected 0x%0h",
               tok_seen, what, got, want);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic check_token();
      cts_pkg::rsp_type want;
      if (token_expect.size() == 0) begin
         report_mismatch("token with none expected, kind", 32'(rsp_kind), 32'd0);
      end else begin
         want = token_expect.pop_front();
         check_field("kind", 32'(rsp_kind), 32'(want.kind));
         check_field("keyword", 32'(rsp_keyword), 32'(want.keyword));
         check_field("start_offset", rsp_start_offset, want.start_offset);
         check_field("length", 32'(rsp_length), 32'(want.length));
         check_field("last", 32'(rsp_last), 32'(want.last));
      end
      tok_seen++;
   endtask

   // Rising edge: compare rsp beats, predict for req beats. Both handshakes
   // are sampled here only, after the falling-edge drive has settled.
   always @(posedge clock) begin
      if (reset) begin
         sc_mode  = SM_IDLE;
         sc_pend  = 8'h00;
         sc_word  = '0;
         sc_start = '0;
         sc_len   = '0;
         sc_pos   = '0;
         sc_done  = 1'b0;
         req_fire    <= 1'b0;
         stream_idle <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_token();
         if (req_valid && !req_stall) predict_tokens(req_ch, req_end_mark);
         req_fire    <= req_valid && !req_stall;
         stream_idle <= (char_q.size() == 0) && !req_valid && (token_expect.size() == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Driver: falling edge. A beat on offer stays put until taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      char_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // still stalled: keep valid and payload
      end else if (char_q.size() != 0 && $urandom_range(99) >= send_idle) begin
         nxt = char_q.pop_front();
         req_valid    <= 1'b1;
         req_ch       <= nxt.ch;
         req_end_mark <= nxt.endm;
      end else begin
         req_valid    <= 1'b0;
         req_ch       <= 8'($urandom);
         req_end_mark <= 1'b0;
      end
   end

   // Receiver stall: random per phase, plus one long hold-off on request
   // so the result queue fills and the block pushes back on req.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req && !hold_used) begin
         hold_cnt  <= 80;
         hold_used <= 1'b1;
         rsp_stall <= 1'b1;
      end else if (hold_cnt != 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_char(input logic [7:0] c);
      char_q.push_back('{ch: c, endm: 1'b0});
      chars_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   task automatic queue_end();
      char_q.push_back('{ch: 8'($urandom_range(255)), endm: 1'b1});
   endtask

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(1) ? cts_pkg::CH_LA : cts_pkg::CH_UA) + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(3))
         0:       return cts_pkg::CH_0 + 8'($urandom_range(9));
         1:       return cts_pkg::CH_UNDER;
         default: return rand_letter();
      endcase
   endfunction

   // one mostly well-formed token with random content, sometimes noise
   task automatic queue_random_token();
      logic [7:0] b;
      case ($urandom_range(15))
         0, 1: begin
            repeat ($urandom_range(5, 1)) queue_char(cts_pkg::CH_0 + 8'($urandom_range(9)));
            if ($urandom_range(9) < 4) begin
               queue_char(cts_pkg::CH_DOT);
               repeat ($urandom_range(3)) queue_char(cts_pkg::CH_0 + 8'($urandom_range(9)));
               if ($urandom_range(9) == 0) queue_char(cts_pkg::CH_DOT);
            end
         end
         2, 3: begin
            queue_char(rand_letter());
            repeat ($urandom_range(8)) queue_char(rand_word_char());
         end
         4, 5: begin
            queue_text(kw_words[$urandom_range(5)]);
            if ($urandom_range(4) == 0) queue_char(rand_word_char());
         end
         6: begin
            queue_char(op_chars[$urandom_range(3)]);
            queue_char(follow[$urandom_range(7)]);
         end
         7: begin
            queue_char(op_chars[$urandom_range(3)]);
            queue_char(cts_pkg::CH_EQ);
         end
         8: begin
            // trailing blank keeps a lone slash from opening a comment
            queue_char(single_ops[$urandom_range(4)]);
            queue_char(cts_pkg::CH_SPACE);
         end
         9: queue_char(delims[$urandom_range(4)]);
         10: begin
            queue_text("//");
            repeat ($urandom_range(8)) queue_char(8'($urandom_range(255)));
            queue_char($urandom_range(1) ? cts_pkg::CH_LF : cts_pkg::CH_CR);
         end
         11: begin
            queue_text("/*");
            if ($urandom_range(3) == 0) queue_char(cts_pkg::CH_SLASH);
            repeat ($urandom_range(10)) begin
               if ($urandom_range(4) == 0) queue_char(8'h80 | 8'($urandom_range(127)));
               else queue_char(cmt_fill[$urandom_range(3)]);
            end
            queue_text("*/ ");
         end
         12: repeat ($urandom_range(3, 1)) queue_char(blanks[$urandom_range(5)]);
         13: begin
            b = 8'($urandom_range(255));
            queue_char((b == cts_pkg::CH_SLASH) ? 8'h3F : b);
         end
         14: begin
            queue_char($urandom_range(1) ? cts_pkg::CH_DOT : cts_pkg::CH_UNDER);
            if ($urandom_range(1)) queue_char(rand_letter());
         end
         default: queue_text(stmts[$urandom_range(4)]);
      endcase
      if ($urandom_range(1)) queue_char(blanks[$urandom_range(5)]);
   endtask

   task automatic fill_random(input int n);
      int target;
      target = chars_queued + n;
      while (chars_queued < target) queue_random_token();
   endtask

   // sender pause: returns at a falling edge once all is sent and checked
   task automatic wait_drained();
      do @(negedge clock); while (!stream_idle);
   endtask

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: keyword, incdec, number with a second point, leading
      // point and underscore, slash-star-slash inside a comment, compound
      // op, a char that ends one token and starts another, byte extremes
      queue_text("do{x++;}1.2._./*/*/a-=b/c");
      queue_char(8'hFF);
      queue_char(8'h00);
      wait_drained();

      fill_random(190);
      wait_drained();

      send_idle = 87;
      recv_idle = 33;
      fill_random(190);
      wait_drained();

      // no idling; the long hold-off backs the block up into req
      send_idle = 0;
      recv_idle = 0;
      fill_random(190);
      hold_req = 1'b1;
      wait_drained();

      // end of input from a random state, ignored chars, repeat end mark
      send_idle = 33;
      recv_idle = 33;
      queue_text(tails[$urandom_range(7)]);
      queue_end();
      queue_char(8'($urandom_range(255)));
      queue_char(8'($urandom_range(255)));
      queue_end();
      wait_drained();

      repeat (8) @(posedge clock);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #(12 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
